[rtl/pcfdm_pkg.sv]
// ----------------------------------------------------------------------------
// pcfdm_pkg
// Shared constants, status codes and control structs for the PWM capture
// frequency and duty meter.
// ----------------------------------------------------------------------------
package pcfdm_pkg;

	localparam int unsigned CHANNELS_DEF   = 2;
	localparam int unsigned COUNT_BITS_DEF = 16;

	localparam int unsigned CAPTURE_W = 16;
	localparam int unsigned TICK_W    = 24;
	localparam int unsigned FREQ_W    = 16;
	localparam int unsigned DUTY_W    = 14;
	localparam int unsigned STATUS_W  = 2;

	localparam int unsigned TICK_RESET = 1000000;
	localparam int unsigned DUTY_FULL  = 10000;
	localparam int unsigned FREQ_MAX   = 65535;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK          = 2'd0,
		STATUS_ZERO_PERIOD = 2'd1,
		STATUS_CLAMPED     = 2'd2
	} status_code_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_load;    // register an accepted transaction
		logic open_meas;   // store the rising edge of a new measurement
		logic close_meas;  // form period and high time, free the channel
		logic mul_load;    // register high time times full-scale duty
		logic div_start;   // launch both divisions
		logic emit_first;  // load a pending result
		logic emit_zero;   // load a zero-period result
		logic emit_meas;   // load a completed measurement
	} pcfdm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ch_ok;
		logic seen;
		logic period_zero;
		logic div_busy;
		logic out_free;
	} pcfdm_sts_t;

endpackage

[rtl/pcfdm_div.sv]
// ----------------------------------------------------------------------------
// pcfdm_div
// Two-lane radix-2 restoring divider: both dividends share one divisor and
// one quotient bit of each lane is formed per cycle.
// ----------------------------------------------------------------------------
module pcfdm_div #(
	parameter int unsigned DIVIDEND_W = 30,
	parameter int unsigned DIVISOR_W  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend_a,
	input  logic [DIVIDEND_W-1:0] dividend_b,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient_a,
	output logic [DIVIDEND_W-1:0] quotient_b
);

	localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dvd_a_q, dvd_b_q;
	logic [DIVISOR_W-1:0]  rem_a_q, rem_b_q, dsr_q;

	logic [DIVISOR_W:0]    part_a, part_b, trial_a, trial_b;
	logic [DIVISOR_W-1:0]  rem_a_d, rem_b_d;

	// The quotient bits shift in behind the dividend, so once every bit has
	// been consumed the dividend register holds the quotient.
	always_comb begin
		part_a  = {rem_a_q, dvd_a_q[DIVIDEND_W-1]};
		part_b  = {rem_b_q, dvd_b_q[DIVIDEND_W-1]};
		trial_a = part_a - {1'b0, dsr_q};
		trial_b = part_b - {1'b0, dsr_q};
		rem_a_d = trial_a[DIVISOR_W] ? part_a[DIVISOR_W-1:0] : trial_a[DIVISOR_W-1:0];
		rem_b_d = trial_b[DIVISOR_W] ? part_b[DIVISOR_W-1:0] : trial_b[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_a_q <= dividend_a;
			dvd_b_q <= dividend_b;
			rem_a_q <= '0;
			rem_b_q <= '0;
			dsr_q   <= divisor;
		end else if (busy_q) begin
			dvd_a_q <= {dvd_a_q[DIVIDEND_W-2:0], ~trial_a[DIVISOR_W]};
			dvd_b_q <= {dvd_b_q[DIVIDEND_W-2:0], ~trial_b[DIVISOR_W]};
			rem_a_q <= rem_a_d;
			rem_b_q <= rem_b_d;
		end
	end

	assign busy       = busy_q;
	assign quotient_a = dvd_a_q;
	assign quotient_b = dvd_b_q;

endmodule

[rtl/pcfdm_dp.sv]
// ----------------------------------------------------------------------------
// pcfdm_dp
// Datapath: per-channel edge store, span subtraction, duty scaling, the
// shared divider, result saturation and the output register.
// ----------------------------------------------------------------------------
module pcfdm_dp import pcfdm_pkg::*; #(
	parameter int unsigned CHANNELS   = CHANNELS_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcfdm_cmd_t           cmd,
	output pcfdm_sts_t           sts,
	input  logic                 cfg_wr_en,
	input  logic [TICK_W-1:0]    cfg_wr_data,
	input  logic                 channel,
	input  logic [CAPTURE_W-1:0] rise_capture,
	input  logic [CAPTURE_W-1:0] fall_capture,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 channel_out,
	output logic                 done_res,
	output logic [FREQ_W-1:0]    frequency_hz,
	output logic [DUTY_W-1:0]    duty_centipercent,
	output logic [STATUS_W-1:0]  status
);

	localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned WIDE_W   = (COUNT_BITS > CAPTURE_W) ? COUNT_BITS : CAPTURE_W;
	localparam int unsigned PROD_W   = COUNT_BITS + DUTY_W;
	localparam int unsigned DIV_W    = (PROD_W > TICK_W) ? PROD_W : TICK_W;

	logic [TICK_W-1:0]     tick_q;
	logic [CH_IDX_W-1:0]   ch_q;
	logic [COUNT_BITS-1:0] rise_q, fall_q;
	logic [COUNT_BITS-1:0] first_edge_q [CHANNELS];
	logic [CHANNELS-1:0]   seen_q;
	logic [COUNT_BITS-1:0] period_q, high_q;
	logic [PROD_W-1:0]     prod_q;

	logic                  out_valid_q;
	logic                  channel_q, done_q;
	logic [FREQ_W-1:0]     freq_q;
	logic [DUTY_W-1:0]     duty_q;
	logic [STATUS_W-1:0]   status_q;

	logic [WIDE_W-1:0]     rise_wide, fall_wide;
	logic [DIV_W-1:0]      quo_a, quo_b, duty_red;
	logic                  div_busy;
	logic                  freq_sat, duty_over, red_over;
	logic [FREQ_W-1:0]     freq_val;
	logic [DUTY_W-1:0]     duty_val;
	status_code_t          status_val;

	// Captures are taken modulo the counter width.
	assign rise_wide = WIDE_W'(rise_capture);
	assign fall_wide = WIDE_W'(fall_capture);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_W'(TICK_RESET);
		end else if (cfg_wr_en) begin
			tick_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (cmd.open_meas) begin
			seen_q[ch_q] <= 1'b1;
		end else if (cmd.close_meas) begin
			seen_q[ch_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_load) begin
			ch_q   <= CH_IDX_W'(channel);
			rise_q <= rise_wide[COUNT_BITS-1:0];
			fall_q <= fall_wide[COUNT_BITS-1:0];
		end
		if (cmd.open_meas) begin
			first_edge_q[ch_q] <= rise_q;
		end
		if (cmd.close_meas) begin
			period_q <= rise_q - first_edge_q[ch_q];
			high_q   <= fall_q - first_edge_q[ch_q];
		end
		if (cmd.mul_load) begin
			prod_q <= PROD_W'(high_q) * PROD_W'(DUTY_FULL);
		end
	end

	pcfdm_div #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (COUNT_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.div_start),
		.dividend_a (DIV_W'(tick_q)),
		.dividend_b (DIV_W'(prod_q)),
		.divisor    (period_q),
		.busy       (div_busy),
		.quotient_a (quo_a),
		.quotient_b (quo_b)
	);

	// A duty above full scale first loses one full scale; only a value that
	// is still too large is clamped and flagged.
	always_comb begin
		freq_sat  = quo_a > DIV_W'(FREQ_MAX);
		freq_val  = freq_sat ? FREQ_W'(FREQ_MAX) : quo_a[FREQ_W-1:0];
		duty_over = quo_b > DIV_W'(DUTY_FULL);
		duty_red  = quo_b - DIV_W'(DUTY_FULL);
		red_over  = duty_red > DIV_W'(DUTY_FULL);
		if (!duty_over) begin
			duty_val = quo_b[DUTY_W-1:0];
		end else if (red_over) begin
			duty_val = DUTY_W'(DUTY_FULL);
		end else begin
			duty_val = duty_red[DUTY_W-1:0];
		end
		status_val = (freq_sat || (duty_over && red_over)) ? STATUS_CLAMPED : STATUS_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_first || cmd.emit_zero || cmd.emit_meas) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_first) begin
			channel_q <= ch_q[0];
			done_q    <= 1'b0;
			freq_q    <= '0;
			duty_q    <= '0;
			status_q  <= STATUS_OK;
		end else if (cmd.emit_zero) begin
			channel_q <= ch_q[0];
			done_q    <= 1'b1;
			freq_q    <= '0;
			duty_q    <= '0;
			status_q  <= STATUS_ZERO_PERIOD;
		end else if (cmd.emit_meas) begin
			channel_q <= ch_q[0];
			done_q    <= 1'b1;
			freq_q    <= freq_val;
			duty_q    <= duty_val;
			status_q  <= status_val;
		end
	end

	assign sts.ch_ok       = (32'(channel) < CHANNELS);
	assign sts.seen        = seen_q[ch_q];
	assign sts.period_zero = (period_q == '0);
	assign sts.div_busy    = div_busy;
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid         = out_valid_q;
	assign channel_out       = channel_q;
	assign done_res          = done_q;
	assign frequency_hz      = freq_q;
	assign duty_centipercent = duty_q;
	assign status            = status_q;

endmodule

[rtl/pcfdm_ctrl.sv]
// ----------------------------------------------------------------------------
// pcfdm_ctrl
// Controller: sequences one capture transaction at a time through edge
// lookup, scaling, division and result hand-off.
// ----------------------------------------------------------------------------
module pcfdm_ctrl import pcfdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  pcfdm_sts_t sts,
	output pcfdm_cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE       = 8'b0000_0001,
		ST_EVAL       = 8'b0000_0010,
		ST_MUL        = 8'b0000_0100,
		ST_START      = 8'b0000_1000,
		ST_DIV        = 8'b0001_0000,
		ST_EMIT_FIRST = 8'b0010_0000,
		ST_EMIT_ZERO  = 8'b0100_0000,
		ST_EMIT_MEAS  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				// Transactions on a channel beyond the configured count are dropped.
				if (in_valid && sts.ch_ok) begin
					cmd.cap_load = 1'b1;
					state_d      = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.seen) begin
					cmd.close_meas = 1'b1;
					state_d        = ST_MUL;
				end else begin
					cmd.open_meas = 1'b1;
					state_d       = ST_EMIT_FIRST;
				end
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = sts.period_zero ? ST_EMIT_ZERO : ST_START;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_EMIT_MEAS;
				end
			end
			ST_EMIT_FIRST: begin
				if (sts.out_free) begin
					cmd.emit_first = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_EMIT_ZERO: begin
				if (sts.out_free) begin
					cmd.emit_zero = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EMIT_MEAS: begin
				if (sts.out_free) begin
					cmd.emit_meas = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

[rtl/pwm_capture_freq_duty_meter_unit.sv]
// A first-edge transaction passes the evaluate state and then its emit state; a
// zero period passes evaluate, multiply and emit; a full measurement passes
// evaluate, multiply, start and the radix-2 divider, one bit a cycle, then emit.
// One transaction is in flight at a time, so a new one is accepted only once the
// last has been emitted or dropped; the output register holds the result.
// Reset clears the seen flags and output valid and sets the tick rate to 1 MHz.
// ----------------------------------------------------------------------------
// pwm_capture_freq_duty_meter_unit
// Measures PWM frequency and positive duty per channel from pairs of rising
// and falling timer captures.
// ----------------------------------------------------------------------------
module pwm_capture_freq_duty_meter_unit import pcfdm_pkg::*; #(
	parameter int unsigned CHANNELS   = CHANNELS_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [TICK_W-1:0]    cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 channel,
	input  logic [CAPTURE_W-1:0] rise_capture,
	input  logic [CAPTURE_W-1:0] fall_capture,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 channel_out,
	output logic                 done_res,
	output logic [FREQ_W-1:0]    frequency_hz,
	output logic [DUTY_W-1:0]    duty_centipercent,
	output logic [STATUS_W-1:0]  status
);

	pcfdm_cmd_t cmd;
	pcfdm_sts_t sts;

	pcfdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcfdm_dp #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.channel           (channel),
		.rise_capture      (rise_capture),
		.fall_capture      (fall_capture),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.channel_out       (channel_out),
		.done_res          (done_res),
		.frequency_hz      (frequency_hz),
		.duty_centipercent (duty_centipercent),
		.status            (status)
	);

endmodule

[rtl/pcfdm_checker.sv]
// ----------------------------------------------------------------------------
// pcfdm_checker
// Port-level checks for the PWM capture meter, bound to the top level.
// ----------------------------------------------------------------------------
module pcfdm_checker import pcfdm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 channel,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 channel_out,
	input logic                 done_res,
	input logic [FREQ_W-1:0]    frequency_hz,
	input logic [DUTY_W-1:0]    duty_centipercent,
	input logic [STATUS_W-1:0]  status
);

	// A held result must not change under it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(channel_out)
			&& $stable(done_res) && $stable(frequency_hz)
			&& $stable(duty_centipercent) && $stable(status)))
		else $error("result changed while stalled");

	// Channel zero always exists, so its transaction occupies the block.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !channel) |=> in_stall)
		else $error("input not stalled after a transaction was taken");

	a_pending_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !done_res) |-> (frequency_hz == '0
			&& duty_centipercent == '0 && status == STATUS_OK))
		else $error("pending result carries measurement data");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_centipercent <= DUTY_W'(DUTY_FULL)
			&& (status == STATUS_OK || status == STATUS_ZERO_PERIOD
			|| status == STATUS_CLAMPED)))
		else $error("duty or status out of range");

	// Zero period reports no frequency and no duty.
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_ZERO_PERIOD) |-> (done_res
			&& frequency_hz == '0 && duty_centipercent == '0))
		else $error("zero-period result malformed");

endmodule

bind pwm_capture_freq_duty_meter_unit pcfdm_checker u_pcfdm_checker (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the PWM capture frequency and duty meter.
// Capture transactions are driven per channel, and each one is run through
// a local model of the meter that predicts its result. Every result leaving
// the block is compared field by field with the oldest prediction. Directed
// cases come first, then random measurement traffic under several tick rates.
// Both handshakes idle at random, and one long output hold fills the block.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcfdm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef struct {
		logic                ch;
		logic                done;
		logic [FREQ_W-1:0]   freq;
		logic [DUTY_W-1:0]   duty;
		status_code_t        st;
	} meas_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [TICK_W-1:0]    cfg_wr_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 channel;
	logic [CAPTURE_W-1:0] rise_capture;
	logic [CAPTURE_W-1:0] fall_capture;
	logic                 out_valid;
	logic                 out_stall;
	logic                 channel_out;
	logic                 done_res;
	logic [FREQ_W-1:0]    frequency_hz;
	logic [DUTY_W-1:0]    duty_centipercent;
	logic [STATUS_W-1:0]  status;

	// Local copy of the meter state and its tick rate register.
	logic [CAPTURE_W-1:0] rise_store [CHANNELS_DEF];
	logic                 rise_held  [CHANNELS_DEF];
	logic [TICK_W-1:0]    tick_model;

	meas_t       pending_meas [$];
	int unsigned err_count;
	int unsigned sent_cnt;
	int unsigned meas_cnt;
	int unsigned zero_cnt;
	int unsigned clamp_cnt;
	int unsigned tick_writes;
	int unsigned burst_left;
	int unsigned cycle_cnt;
	bit          hold_start;
	int unsigned hold_cnt;
	int unsigned stall_mode;
	int unsigned mode_left;
	int unsigned pat_cnt;

	pwm_capture_freq_duty_meter_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.channel           (channel),
		.rise_capture      (rise_capture),
		.fall_capture      (fall_capture),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.channel_out       (channel_out),
		.done_res          (done_res),
		.frequency_hz      (frequency_hz),
		.duty_centipercent (duty_centipercent),
		.status            (status)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_cnt, pending_meas.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Works out the result of one capture and advances the channel state.
	function automatic meas_t predict_meter(input logic ch,
		input logic [CAPTURE_W-1:0] rise, input logic [CAPTURE_W-1:0] fall);
		meas_t                r;
		logic [CAPTURE_W-1:0] period;
		logic [CAPTURE_W-1:0] high;
		longint unsigned      q;
		longint unsigned      d;
		r.ch   = ch;
		r.done = 1'b0;
		r.freq = '0;
		r.duty = '0;
		r.st   = STATUS_OK;
		if (!rise_held[ch]) begin
			rise_store[ch] = rise;
			rise_held[ch]  = 1'b1;
			return r;
		end
		rise_held[ch]  = 1'b0;
		period         = rise - rise_store[ch];
		high           = fall - rise_store[ch];
		rise_store[ch] = '0;
		r.done         = 1'b1;
		if (period == 0) begin
			r.st = STATUS_ZERO_PERIOD;
			return r;
		end
		q = longint'(tick_model) / longint'(period);
		if (q > FREQ_MAX) begin
			q    = FREQ_MAX;
			r.st = STATUS_CLAMPED;
		end
		d = longint'(high) * longint'(DUTY_FULL) / longint'(period);
		// A duty between one and two full scales folds back once without a flag.
		if (d > DUTY_FULL) begin
			d -= DUTY_FULL;
			if (d > DUTY_FULL) begin
				d    = DUTY_FULL;
				r.st = STATUS_CLAMPED;
			end
		end
		r.freq = q[FREQ_W-1:0];
		r.duty = d[DUTY_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		err_count++;
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		meas_t m;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_meas.size() == 0) begin
				report_mismatch("unrequested result on channel", 32'(channel_out), 0);
			end else begin
				m = pending_meas.pop_front();
				if (channel_out !== m.ch)
					report_mismatch("channel_out", 32'(channel_out), 32'(m.ch));
				if (done_res !== m.done)
					report_mismatch("done_res", 32'(done_res), 32'(m.done));
				if (frequency_hz !== m.freq)
					report_mismatch("frequency_hz", 32'(frequency_hz), 32'(m.freq));
				if (duty_centipercent !== m.duty)
					report_mismatch("duty_centipercent", 32'(duty_centipercent),
						32'(m.duty));
				if (status !== m.st)
					report_mismatch("status", 32'(status), 32'(m.st));
				if (m.done)
					meas_cnt++;
				if (m.st == STATUS_ZERO_PERIOD)
					zero_cnt++;
				if (m.st == STATUS_CLAMPED)
					clamp_cnt++;
			end
		end
	end

	// The receiver switches between several stall patterns, and a requested
	// hold overrides them all for a long stretch.
	always @(negedge clk) begin
		if (hold_start) begin
			hold_cnt   = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(100, 400);
		end
		mode_left--;
		pat_cnt++;
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall = 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 2) == 0);
				2: out_stall = ((pat_cnt % 7) < 3);
				default: out_stall = ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	// Called and left at a falling edge.
	task automatic send_capture(input logic ch, input logic [CAPTURE_W-1:0] rise,
		input logic [CAPTURE_W-1:0] fall);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid     = 1'b1;
		channel      = ch;
		rise_capture = rise;
		fall_capture = fall;
		do @(posedge clk); while (in_stall);
		pending_meas.push_back(predict_meter(ch, rise, fall));
		sent_cnt++;
		burst_left--;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic measure(input logic ch, input logic [CAPTURE_W-1:0] start,
		input logic [CAPTURE_W-1:0] period, input logic [CAPTURE_W-1:0] high);
		send_capture(ch, start, CAPTURE_W'($urandom));
		send_capture(ch, start + period, start + high);
	endtask

	task automatic wait_idle();
		while (pending_meas.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_tick(input logic [TICK_W-1:0] rate);
		wait_idle();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = rate;
		@(negedge clk);
		cfg_wr_en  = 1'b0;
		tick_model = rate;
		tick_writes++;
	endtask

	// One capture: opens a measurement where none is open, else mostly a well-formed close.
	task automatic random_capture();
		logic                 ch;
		logic [CAPTURE_W-1:0] base;
		logic [CAPTURE_W-1:0] period;
		logic [CAPTURE_W-1:0] high;
		int unsigned          sel;
		ch   = 1'($urandom_range(0, 1));
		base = rise_store[ch];
		sel  = $urandom_range(0, 19);
		if (!rise_held[ch] || sel == 0) begin
			send_capture(ch, CAPTURE_W'($urandom), CAPTURE_W'($urandom));
		end else if (sel == 1) begin
			send_capture(ch, base, CAPTURE_W'($urandom));
		end else begin
			case ($urandom_range(0, 3))
				0: period = CAPTURE_W'($urandom_range(1, 40));
				1: period = CAPTURE_W'($urandom_range(41, 1000));
				2: period = CAPTURE_W'($urandom_range(1001, 20000));
				default: period = CAPTURE_W'($urandom_range(20001, 65535));
			endcase
			sel = $urandom_range(0, 9);
			if (sel < 7)
				high = CAPTURE_W'($urandom_range(0, period));
			else if (sel < 9)
				high = period + CAPTURE_W'($urandom_range(0, period));
			else
				high = CAPTURE_W'($urandom);
			send_capture(ch, base + period, base + high);
		end
	endtask

	task automatic test_first_edges();
		// Interleaved channels with the capture extremes and wrap of the timer.
		send_capture(1'b0, 16'h0000, 16'h0000);
		send_capture(1'b1, 16'hFFFF, 16'hFFFF);
		send_capture(1'b0, 16'hFFFF, 16'hFFFF);
		send_capture(1'b1, 16'h0000, 16'hFFFF);
		measure(1'b0, 16'h5A5A, 16'hA5A5, 16'h1234);
	endtask

	task automatic test_zero_period();
		measure(1'b1, 16'h8000, 16'h0000, 16'h0010);
	endtask

	task automatic test_duty_fold();
		measure(1'b0, 16'hFC00, 16'd1000, 16'd1500);
		measure(1'b0, 16'h0100, 16'd1000, 16'd2000);
		measure(1'b1, 16'h0200, 16'd1000, 16'd2001);
		measure(1'b1, 16'h0300, 16'd1000, 16'd60000);
	endtask

	task automatic test_tick_extremes();
		write_tick(24'd0);
		measure(1'b0, 16'h0010, 16'd100, 16'd30);
		write_tick(24'd1);
		measure(1'b1, 16'h0020, 16'd1, 16'd1);
		write_tick(24'd16000000);
		measure(1'b0, 16'h0030, 16'd244, 16'd100);
		measure(1'b1, 16'h0040, 16'd245, 16'd245);
		write_tick(24'hFFFFFF);
		measure(1'b0, 16'h0050, 16'd255, 16'd0);
	endtask

	task automatic test_backpressure();
		int unsigned i;
		wait_idle();
		hold_start = 1'b1;
		for (i = 0; i < 12; i++)
			random_capture();
	endtask

	task automatic test_random_phase(input logic [TICK_W-1:0] rate, input int unsigned count);
		int unsigned i;
		write_tick(rate);
		for (i = 0; i < count; i++)
			random_capture();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		in_valid     = 1'b0;
		channel      = 1'b0;
		rise_capture = '0;
		fall_capture = '0;
		out_stall    = 1'b0;
		hold_start   = 1'b0;
		hold_cnt     = 0;
		mode_left    = 0;
		pat_cnt      = 0;
		burst_left   = 0;
		cycle_cnt    = 0;
		err_count    = 0;
		sent_cnt     = 0;
		meas_cnt     = 0;
		zero_cnt     = 0;
		clamp_cnt    = 0;
		tick_writes  = 0;
		tick_model   = TICK_W'(TICK_RESET);
		for (int c = 0; c < CHANNELS_DEF; c++) begin
			rise_store[c] = '0;
			rise_held[c]  = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_first_edges();
		test_zero_period();
		test_duty_fold();
		test_tick_extremes();
		test_random_phase(TICK_W'(TICK_RESET), 220);
		test_backpressure();
		test_random_phase(24'd1, 220);
		test_random_phase(24'd16000000, 220);
		test_random_phase(24'hFFFFFF, 220);
		test_random_phase(24'd0, 200);
		test_random_phase(TICK_W'($urandom_range(1, 16000000)), 220);

		wait_idle();
		repeat (60) @(posedge clk);
		$display("Run covered %0d capture transactions and %0d completed measurements,",
			sent_cnt, meas_cnt);
		$display("of which %0d had a zero period and %0d were clamped, over %0d tick rates.",
			zero_cnt, clamp_cnt, tick_writes + 1);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
